>>> rtl/hbm_pkg.sv
package hbm_pkg;

  localparam int FRACTION_BITS = 16;

  typedef logic signed [31:0] fx_t;
  typedef logic signed [33:0] opd_t;
  typedef logic signed [67:0] wide_t;

  localparam fx_t FX_MAX = 32'sh7fff_ffff;
  localparam fx_t FX_MIN = 32'sh8000_0000;
  localparam fx_t FX_ONE = fx_t'(64'sd1 <<< FRACTION_BITS);
  localparam int  MUL_RND = (1 << FRACTION_BITS) >> 1;

  localparam fx_t         LEFT_RST  = -32'sd65536;
  localparam fx_t         RIGHT_RST = 32'sd65536;
  localparam logic [30:0] MASS_RST  = 31'd65536;
  localparam logic [30:0] HALF_RST  = 31'd3277;

  localparam int DIV_NW = 32 + FRACTION_BITS;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam logic [63:0] TWO_PI_Q61 = 64'hC90F_DAA2_2168_C235;
  localparam int          TP_SHIFT   = 61 - 2 * FRACTION_BITS;
  localparam logic [63:0] TWO_PI_FX  = ((TWO_PI_Q61 >> (TP_SHIFT - 1)) + 64'd1) >> 1;
  localparam int          MOD_STEPS  = 63 - 2 * FRACTION_BITS;
  localparam int          ANG_RSH    = (2 * FRACTION_BITS >= 30) ? 2 * FRACTION_BITS - 30 : 0;
  localparam int          ANG_LSH    = (2 * FRACTION_BITS >= 30) ? 0 : 30 - 2 * FRACTION_BITS;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_RS    = 30 - FRACTION_BITS;
  localparam int CORDIC_RND   = (1 << CORDIC_RS) >> 1;
  localparam int CNT_W = ($clog2(MOD_STEPS) > 5) ? $clog2(MOD_STEPS) : 5;

  typedef enum logic [1:0] {
    CFG_LEFT, CFG_RIGHT, CFG_MASS, CFG_HALF
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DV_IDLE, DV_RUN, DV_FIN
  } dv_state_e;

  typedef enum logic [2:0] {
    CS_IDLE, CS_MOD, CS_FOLD, CS_ROT, CS_OUT
  } cs_state_e;

  typedef enum logic [1:0] {
    BK_IDLE, BK_ISSUE, BK_MULW, BK_WAIT
  } bk_state_e;

  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_SC, OP_ADD, OP_AVG, OP_ACC
  } op_e;

  typedef enum logic [4:0] {
    S_MW, S_MW2, S_K, S_WD, S_SC,
    S_AVG, S_SH, S_D, S_Q, S_TA, S_TB, S_TC, S_PH,
    S_XA, S_XB, S_X, S_PA, S_PB, S_PC, S_P,
    S_DIFF, S_CD, S_PRE, S_ERR, S_T, S_SUM, S_ACC
  } step_e;

  typedef enum logic [3:0] {
    R_MW, R_MW2, R_K, R_WD, R_CSN, R_X, R_P, R_SH, R_D, R_Q,
    R_TA, R_TB, R_TC, R_PH1, R_PH2, R_TMP
  } dst_e;

  typedef struct packed {
    logic [30:0] frequency;
    fx_t         coupling;
    fx_t         position_in;
    fx_t         momentum_in;
    logic        fwd_first;
    logic        bwd_first;
    logic        fwd_second;
    logic        bwd_second;
    fx_t         ref_phase_first;
    fx_t         ref_phase_second;
    logic        last_mode;
  } in_item_t;

  typedef struct packed {
    fx_t  position_out;
    fx_t  momentum_out;
    fx_t  total_action;
    logic action_final;
    logic saturated;
  } out_item_t;

  typedef struct packed {
    logic [30:0] w;
    fx_t         c;
    fx_t         x;
    fx_t         p;
    fx_t         pf1;
    fx_t         pb1;
    fx_t         pf2;
    fx_t         pb2;
    fx_t         r1;
    fx_t         r2;
    logic        last;
  } job_t;

  typedef struct packed {
    fx_t  val;
    logic clip;
  } sat_t;

  function automatic sat_t sat32(wide_t v);
    sat_t r;
    if (v > wide_t'(FX_MAX)) begin
      r.val  = FX_MAX;
      r.clip = 1'b1;
    end else if (v < wide_t'(FX_MIN)) begin
      r.val  = FX_MIN;
      r.clip = 1'b1;
    end else begin
      r.val  = v[31:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  function automatic opd_t ox(fx_t v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic wide_t wx(opd_t v);
    return {{34{v[33]}}, v};
  endfunction

  function automatic logic signed [35:0] atan_q30(logic [4:0] i);
    logic signed [35:0] r;
    unique case (i)
      5'd0:  r = 36'sd843314857;
      5'd1:  r = 36'sd497837830;
      5'd2:  r = 36'sd263043837;
      5'd3:  r = 36'sd133525159;
      5'd4:  r = 36'sd67021687;
      5'd5:  r = 36'sd33543516;
      5'd6:  r = 36'sd16775851;
      5'd7:  r = 36'sd8388437;
      5'd8:  r = 36'sd4194283;
      5'd9:  r = 36'sd2097149;
      default: r = (i < 5'd30) ? (36'sd1 <<< (5'd30 - i)) : 36'sd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/hbm_if.sv
interface hbm_in_if;
  import hbm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface hbm_out_if;
  import hbm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/hbm_div.sv
module hbm_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  hbm_pkg::fx_t num_i,
  input  hbm_pkg::fx_t den_i,
  output logic        done_o,
  output hbm_pkg::fx_t quo_o,
  output logic        clip_o
);
  import hbm_pkg::*;

  localparam logic [DIV_NW-1:0] MAG_NEG = {{(DIV_NW-32){1'b0}}, 32'h8000_0000};
  localparam logic [DIV_NW-1:0] MAG_POS = {{(DIV_NW-32){1'b0}}, 32'h7fff_ffff};

  dv_state_e          state_q, state_d;
  logic [DIV_CW-1:0]  cnt_q;
  logic [31:0]        rem_q, den_q;
  logic [DIV_NW-1:0]  quo_q;
  logic               neg_q, num_neg_q, num_zero_q, den_zero_q;
  logic [32:0]        rem2;
  logic               ge;
  logic [31:0]        num_abs;

  assign rem2    = {rem_q, quo_q[DIV_NW-1]};
  assign ge      = rem2 >= {1'b0, den_q};
  assign num_abs = num_i[31] ? 32'(-num_i) : 32'(num_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    unique case (state_q)
      DV_IDLE: begin
        if (start_i) begin
          state_d = (den_i == '0) ? DV_FIN : DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt_q == DIV_CW'(1)) begin
          state_d = DV_FIN;
        end
      end
      DV_FIN: begin
        done_o  = 1'b1;
        state_d = DV_IDLE;
      end
      default: state_d = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == DV_IDLE && start_i) begin
      neg_q      <= num_i[31] ^ den_i[31];
      num_neg_q  <= num_i[31];
      num_zero_q <= num_i == '0;
      den_zero_q <= den_i == '0;
      den_q      <= den_i[31] ? 32'(-den_i) : 32'(den_i);
      quo_q      <= {num_abs, {FRACTION_BITS{1'b0}}};
      rem_q      <= '0;
      cnt_q      <= DIV_CW'(DIV_NW);
    end else if (state_q == DV_RUN) begin
      rem_q <= ge ? 32'(rem2 - {1'b0, den_q}) : rem2[31:0];
      quo_q <= {quo_q[DIV_NW-2:0], ge};
      cnt_q <= cnt_q - DIV_CW'(1);
    end
  end

  always_comb begin
    quo_o  = '0;
    clip_o = 1'b0;
    if (den_zero_q) begin
      clip_o = 1'b1;
      quo_o  = num_neg_q ? FX_MIN : (num_zero_q ? '0 : FX_MAX);
    end else if (neg_q) begin
      if (quo_q > MAG_NEG) begin
        quo_o  = FX_MIN;
        clip_o = 1'b1;
      end else begin
        quo_o = fx_t'(-quo_q[31:0]);
      end
    end else begin
      if (quo_q > MAG_POS) begin
        quo_o  = FX_MAX;
        clip_o = 1'b1;
      end else begin
        quo_o = fx_t'(quo_q[31:0]);
      end
    end
  end

endmodule

>>> rtl/hbm_cordic.sv
module hbm_cordic (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [30:0]  w_i,
  input  logic [30:0]  h_i,
  output logic         done_o,
  output hbm_pkg::fx_t cs_o,
  output hbm_pkg::fx_t sn_o,
  output logic         clip_o
);
  import hbm_pkg::*;

  cs_state_e          state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [61:0]        theta_q;
  logic signed [33:0] x_q, y_q;
  logic signed [35:0] z_q;
  logic               flip_q;

  logic [65:0]        tps, th_ext;
  logic [63:0]        ash;
  logic signed [35:0] a0, a1, zf;
  logic               fl;
  logic signed [33:0] dx, dy, xf;
  wide_t              xw, yw;
  sat_t               cs_s, sn_s;

  assign tps    = 66'(TWO_PI_FX) << cnt_q;
  assign th_ext = {4'b0, theta_q};
  assign ash    = ({2'b0, theta_q} >> ANG_RSH) << ANG_LSH;
  assign a0     = {1'b0, ash[34:0]};
  assign a1     = (a0 > PI_Q30) ? a0 - TWO_PI_Q30 : a0;
  assign dx     = y_q >>> cnt_q[4:0];
  assign dy     = x_q >>> cnt_q[4:0];

  always_comb begin
    fl = 1'b0;
    zf = a1;
    if (a1 > HALF_PI_Q30) begin
      zf = PI_Q30 - a1;
      fl = 1'b1;
    end else if (a1 < -HALF_PI_Q30) begin
      zf = -PI_Q30 - a1;
      fl = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    done_o  = 1'b0;
    unique case (state_q)
      CS_IDLE: if (start_i) state_d = CS_MOD;
      CS_MOD:  if (cnt_q == '0) state_d = CS_FOLD;
      CS_FOLD: state_d = CS_ROT;
      CS_ROT:  if (cnt_q == CNT_W'(CORDIC_STEPS - 1)) state_d = CS_OUT;
      CS_OUT: begin
        done_o  = 1'b1;
        state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          theta_q <= w_i * h_i;
          cnt_q   <= CNT_W'(MOD_STEPS - 1);
        end
      end
      CS_MOD: begin
        if (th_ext >= tps) begin
          theta_q <= 62'(th_ext - tps);
        end
        cnt_q <= cnt_q - CNT_W'(1);
      end
      CS_FOLD: begin
        z_q    <= zf;
        flip_q <= fl;
        x_q    <= CORDIC_GAIN;
        y_q    <= '0;
        cnt_q  <= '0;
      end
      CS_ROT: begin
        if (z_q >= 0) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_q30(cnt_q[4:0]);
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_q30(cnt_q[4:0]);
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  assign xf   = flip_q ? -x_q : x_q;
  assign xw   = (wx(xf) + wide_t'(CORDIC_RND)) >>> CORDIC_RS;
  assign yw   = (wx(y_q) + wide_t'(CORDIC_RND)) >>> CORDIC_RS;
  assign cs_s = sat32(xw);
  assign sn_s = sat32(yw);

  assign cs_o   = cs_s.val;
  assign sn_o   = sn_s.val;
  assign clip_o = cs_s.clip | sn_s.clip;

endmodule

>>> rtl/hbm_front.sv
module hbm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  hbm_in_if.sink        in_i,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [31:0]   cfg_data_i,
  input  logic          pop_i,
  output logic          job_valid_o,
  output hbm_pkg::job_t job_o,
  output logic [30:0]   mass_o,
  output logic [30:0]   half_o
);
  import hbm_pkg::*;

  fx_t         left_q, right_q;
  logic [30:0] mass_q, half_q;
  job_t        fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;
  job_t        job_d;
  cfg_idx_e    cfg_idx;

  assign cfg_idx = cfg_idx_e'(cfg_idx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= LEFT_RST;
      right_q <= RIGHT_RST;
      mass_q  <= MASS_RST;
      half_q  <= HALF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        CFG_LEFT:  left_q  <= cfg_data_i;
        CFG_RIGHT: right_q <= cfg_data_i;
        CFG_MASS:  mass_q  <= cfg_data_i[30:0];
        CFG_HALF:  half_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  assign mass_o = mass_q;
  assign half_o = half_q;

  // resolve the two-level states into positions on entry
  always_comb begin
    job_d.w    = in_i.data.frequency;
    job_d.c    = in_i.data.coupling;
    job_d.x    = in_i.data.position_in;
    job_d.p    = in_i.data.momentum_in;
    job_d.pf1  = in_i.data.fwd_first  ? right_q : left_q;
    job_d.pb1  = in_i.data.bwd_first  ? right_q : left_q;
    job_d.pf2  = in_i.data.fwd_second ? right_q : left_q;
    job_d.pb2  = in_i.data.bwd_second ? right_q : left_q;
    job_d.r1   = in_i.data.ref_phase_first;
    job_d.r2   = in_i.data.ref_phase_second;
    job_d.last = in_i.data.last_mode;
  end

  assign in_i.ready  = cnt_q != 2'd2;
  assign push        = in_i.valid && in_i.ready;
  assign job_valid_o = cnt_q != 2'd0;
  assign pop         = pop_i && job_valid_o;
  assign job_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/hbm_back.sv
module hbm_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  hbm_pkg::job_t job_i,
  output logic          pop_o,
  input  logic [30:0]   mass_i,
  input  logic [30:0]   half_i,
  hbm_out_if.source     out_o
);
  import hbm_pkg::*;

  bk_state_e state_q, state_d;
  step_e     step_q;
  logic      half_q;
  job_t      job_q;
  fx_t       x_q, p_q, mw_q, mw2_q, k_q, wd_q, cs_q, sn_q, sh_q, d_q, q_q;
  fx_t       ta_q, tb_q, tc_q, ph1_q, ph2_q, tmp_q, sum_q;
  logic      clip_q;
  logic signed [64:0] prod_q;
  out_item_t out_q;
  logic      out_vld_q;

  op_e   op;
  dst_e  dst;
  step_e step_nx;
  logic  toggle;
  opd_t  opa, opb, opc;
  fx_t   pf, pb, rf, ph;
  opd_t  w_o, m_o, h_o;

  logic  start, wb_en, acc_fire, wb_clip;
  fx_t   wb_val;
  sat_t  mul_s, add_s, acc_s;
  wide_t pw;

  logic  div_start, div_done, div_clip;
  fx_t   div_q;
  logic  sc_start, sc_done, sc_clip;
  fx_t   sc_cs, sc_sn;

  assign pf  = half_q ? job_q.pf2 : job_q.pf1;
  assign pb  = half_q ? job_q.pb2 : job_q.pb1;
  assign rf  = half_q ? job_q.r2  : job_q.r1;
  assign ph  = half_q ? ph2_q : ph1_q;
  assign w_o = ox(fx_t'({1'b0, job_q.w}));
  assign m_o = ox(fx_t'({1'b0, mass_i}));
  assign h_o = ox(fx_t'({1'b0, half_i}));

  always_comb begin
    op      = OP_ADD;
    dst     = R_TA;
    opa     = '0;
    opb     = '0;
    opc     = '0;
    step_nx = step_q;
    toggle  = 1'b0;
    unique case (step_q)
      S_MW:   begin op = OP_MUL; dst = R_MW;  opa = m_o; opb = w_o; step_nx = S_MW2; end
      S_MW2:  begin op = OP_MUL; dst = R_MW2; opa = ox(mw_q); opb = w_o; step_nx = S_K; end
      S_K:    begin op = OP_DIV; dst = R_K; opa = ox(job_q.c); opb = ox(mw2_q); step_nx = S_WD; end
      S_WD:   begin op = OP_MUL; dst = R_WD; opa = w_o; opb = h_o; step_nx = S_SC; end
      S_SC:   begin op = OP_SC;  dst = R_CSN; step_nx = S_AVG; end
      S_AVG:  begin op = OP_AVG; dst = R_TMP; opa = ox(pf); opb = ox(pb); step_nx = S_SH; end
      S_SH:   begin op = OP_MUL; dst = R_SH; opa = ox(tmp_q); opb = ox(k_q); step_nx = S_D; end
      S_D:    begin dst = R_D; opa = ox(x_q); opb = -ox(sh_q); step_nx = S_Q; end
      S_Q:    begin op = OP_DIV; dst = R_Q; opa = ox(p_q); opb = ox(mw_q); step_nx = S_TA; end
      S_TA:   begin op = OP_MUL; dst = R_TA; opa = ox(d_q); opb = ox(sn_q); step_nx = S_TB; end
      S_TB:   begin
        op = OP_MUL; dst = R_TB; opa = ox(q_q); opb = ox(cs_q) - ox(FX_ONE);
        step_nx = S_TC;
      end
      S_TC:   begin op = OP_MUL; dst = R_TC; opa = ox(sh_q); opb = ox(wd_q); step_nx = S_PH; end
      S_PH:   begin
        dst = half_q ? R_PH2 : R_PH1;
        opa = ox(ta_q); opb = -ox(tb_q); opc = ox(tc_q); step_nx = S_XA;
      end
      S_XA:   begin op = OP_MUL; dst = R_TA; opa = ox(d_q); opb = ox(cs_q); step_nx = S_XB; end
      S_XB:   begin op = OP_MUL; dst = R_TB; opa = ox(q_q); opb = ox(sn_q); step_nx = S_X; end
      S_X:    begin dst = R_X; opa = ox(ta_q); opb = ox(tb_q); opc = ox(sh_q); step_nx = S_PA; end
      S_PA:   begin op = OP_MUL; dst = R_TA; opa = ox(p_q); opb = ox(cs_q); step_nx = S_PB; end
      S_PB:   begin op = OP_MUL; dst = R_TB; opa = ox(mw_q); opb = ox(d_q); step_nx = S_PC; end
      S_PC:   begin op = OP_MUL; dst = R_TC; opa = ox(tb_q); opb = ox(sn_q); step_nx = S_P; end
      S_P:    begin
        dst = R_P; opa = ox(ta_q); opb = -ox(tc_q); toggle = 1'b1;
        step_nx = half_q ? S_DIFF : S_AVG;
      end
      S_DIFF: begin dst = R_TMP; opa = ox(pf); opb = -ox(pb); step_nx = S_CD; end
      S_CD:   begin op = OP_MUL; dst = R_TMP; opa = ox(job_q.c); opb = ox(tmp_q); step_nx = S_PRE; end
      S_PRE:  begin op = OP_DIV; dst = R_TMP; opa = ox(tmp_q); opb = w_o; step_nx = S_ERR; end
      S_ERR:  begin dst = R_TA; opa = ox(ph); opb = -ox(rf); step_nx = S_T; end
      S_T:    begin
        op = OP_MUL; dst = half_q ? R_PH2 : R_PH1; opa = ox(tmp_q); opb = ox(ta_q);
        toggle = 1'b1; step_nx = half_q ? S_SUM : S_DIFF;
      end
      S_SUM:  begin dst = R_TA; opa = ox(ph1_q); opb = ox(ph2_q); step_nx = S_ACC; end
      S_ACC:  begin op = OP_ACC; opa = ox(sum_q); opb = ox(ta_q); end
      default: ;
    endcase
  end

  assign pw    = (wide_t'(prod_q) + wide_t'(MUL_RND)) >>> FRACTION_BITS;
  assign mul_s = sat32(pw);
  assign add_s = sat32(wx(opa) + wx(opb) + wx(opc));
  assign acc_s = add_s;

  assign start     = (state_q == BK_IDLE) && job_valid_i;
  assign pop_o     = start;
  assign div_start = (state_q == BK_ISSUE) && (op == OP_DIV);
  assign sc_start  = (state_q == BK_ISSUE) && (op == OP_SC);
  assign acc_fire  = (state_q == BK_ISSUE) && (op == OP_ACC) && (!out_vld_q || out_o.ready);

  always_comb begin
    wb_en   = 1'b0;
    wb_val  = add_s.val;
    wb_clip = 1'b0;
    unique case (state_q)
      BK_MULW: begin
        wb_en   = 1'b1;
        wb_val  = mul_s.val;
        wb_clip = mul_s.clip;
      end
      BK_ISSUE: begin
        if (op == OP_ADD) begin
          wb_en   = 1'b1;
          wb_clip = add_s.clip;
        end else if (op == OP_AVG) begin
          wb_en  = 1'b1;
          wb_val = fx_t'((opa + opb) >>> 1);
        end
      end
      BK_WAIT: begin
        if (op == OP_DIV && div_done) begin
          wb_en   = 1'b1;
          wb_val  = div_q;
          wb_clip = div_clip;
        end else if (op == OP_SC && sc_done) begin
          wb_en   = 1'b1;
          wb_clip = sc_clip;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (job_valid_i) state_d = BK_ISSUE;
      BK_ISSUE: begin
        priority case (op)
          OP_MUL:          state_d = BK_MULW;
          OP_DIV, OP_SC:   state_d = BK_WAIT;
          OP_ACC:          if (acc_fire) state_d = BK_IDLE;
          default:         state_d = BK_ISSUE;
        endcase
      end
      BK_MULW: state_d = BK_ISSUE;
      BK_WAIT: if (wb_en) state_d = BK_ISSUE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= S_MW;
      half_q    <= 1'b0;
      clip_q    <= 1'b0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (start) begin
        step_q <= S_MW;
        half_q <= 1'b0;
        clip_q <= 1'b0;
      end else if (wb_en) begin
        step_q <= step_nx;
        clip_q <= clip_q | wb_clip;
        if (toggle) half_q <= ~half_q;
      end
      if (acc_fire) begin
        sum_q     <= job_q.last ? '0 : acc_s.val;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BK_ISSUE && op == OP_MUL) begin
      prod_q <= $signed(opa[31:0]) * $signed(opb[32:0]);
    end
    if (acc_fire) begin
      out_q.position_out <= x_q;
      out_q.momentum_out <= p_q;
      out_q.total_action <= job_q.last ? acc_s.val : '0;
      out_q.action_final <= job_q.last;
      out_q.saturated    <= clip_q | acc_s.clip;
    end
    if (start) begin
      job_q <= job_i;
      x_q   <= job_i.x;
      p_q   <= job_i.p;
    end else if (wb_en) begin
      unique case (dst)
        R_MW:  mw_q  <= wb_val;
        R_MW2: mw2_q <= wb_val;
        R_K:   k_q   <= wb_val;
        R_WD:  wd_q  <= wb_val;
        R_CSN: begin
          cs_q <= sc_cs;
          sn_q <= sc_sn;
        end
        R_X:   x_q   <= wb_val;
        R_P:   p_q   <= wb_val;
        R_SH:  sh_q  <= wb_val;
        R_D:   d_q   <= wb_val;
        R_Q:   q_q   <= wb_val;
        R_TA:  ta_q  <= wb_val;
        R_TB:  tb_q  <= wb_val;
        R_TC:  tc_q  <= wb_val;
        R_PH1: ph1_q <= wb_val;
        R_PH2: ph2_q <= wb_val;
        R_TMP: tmp_q <= wb_val;
        default: ;
      endcase
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  hbm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (opa[31:0]),
    .den_i   (opb[31:0]),
    .done_o  (div_done),
    .quo_o   (div_q),
    .clip_o  (div_clip)
  );

  hbm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sc_start),
    .w_i     (job_q.w),
    .h_i     (half_i),
    .done_o  (sc_done),
    .cs_o    (sc_cs),
    .sn_o    (sc_sn),
    .clip_o  (sc_clip)
  );

endmodule

>>> rtl/harmonic_bath_mode_step.sv
// Advances one bath mode per request over two exact half steps and sums the residual
// action, reporting and clearing the sum on the last mode. At Q16.16 five bit-serial
// divisions of 48 steps each dominate the work of a request, followed by the
// sine/cosine unit (angle reduction of 31 steps and 30 rotations) and 25 multiplies
// on a single shared multiplier. Up to two requests queue ahead of the
// sequencer, and a finished result waits in an output register while the next request
// is worked on. Configuration writes take effect at once and belong between requests.
module harmonic_bath_mode_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  hbm_in_if.sink      in_i,
  hbm_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import hbm_pkg::*;

  job_t        job;
  logic        job_valid, pop;
  logic [30:0] mass, half;

  hbm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pop_i       (pop),
    .job_valid_o (job_valid),
    .job_o       (job),
    .mass_o      (mass),
    .half_o      (half)
  );

  hbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .pop_o       (pop),
    .mass_i      (mass),
    .half_i      (half),
    .out_o       (out_o)
  );

endmodule

>>> sim/tb.sv
module tb;
  import hbm_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int DRAIN_CYCLES   = 500;

  localparam longint unsigned TWO_PI_Q61_C = 64'hC90F_DAA2_2168_C235;
  localparam longint PI_Q30_C      = 64'sd3373259426;
  localparam longint HALF_PI_Q30_C = 64'sd1686629713;
  localparam longint TWO_PI_Q30_C  = 64'sd6746518852;
  localparam longint GAIN_Q30_C    = 64'sd652032874;
  localparam longint ONE_FX        = 64'sd65536;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  hbm_in_if  in_if ();
  hbm_out_if out_if ();

  harmonic_bath_mode_step u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  longint    arctan_tbl [30] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                                 33543516, 16775851, 8388437, 4194283, 2097149,
                                 1048576, 524288, 262144, 131072, 65536, 32768,
                                 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
                                 32, 16, 8, 4, 2};

  longint    pos_left, pos_right, mass_q, half_q, bath_action;
  bit        clip_flag;
  out_item_t mode_results_q [$];
  int        mismatches;
  int        idle_cycles;
  int        send_gap_pct;
  int        rcv_stall_pct;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clip_flag = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_flag = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clip32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint qdiv(longint a, longint b);
    if (b == 0) begin
      clip_flag = 1'b1;
      return (a > 0) ? 64'sd2147483647 : ((a < 0) ? -64'sd2147483648 : 64'sd0);
    end
    return clip32((a * 64'sd65536) / b);
  endfunction

  function automatic void rotate(longint unsigned w, longint unsigned h,
                                 output longint cs, output longint sn);
    longint unsigned theta, tp, r;
    longint ang, x, y, nx;
    bit flip;
    theta = w * h;
    tp = ((TWO_PI_Q61_C >> 28) + 64'd1) >> 1;
    r = theta % tp;
    ang = longint'(r >> 2);
    x = GAIN_Q30_C;
    y = 0;
    flip = 1'b0;
    if (ang > PI_Q30_C) ang -= TWO_PI_Q30_C;
    if (ang > HALF_PI_Q30_C) begin
      ang = PI_Q30_C - ang;
      flip = 1'b1;
    end else if (ang < -HALF_PI_Q30_C) begin
      ang = -PI_Q30_C - ang;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (ang >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        ang -= arctan_tbl[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        ang += arctan_tbl[i];
      end
      x = nx;
    end
    if (flip) x = -x;
    cs = clip32((x + 64'sd8192) >>> 14);
    sn = clip32((y + 64'sd8192) >>> 14);
  endfunction

  function automatic longint evolve_half(inout longint x, inout longint p, input longint shift,
                                         input longint mw, input longint wd,
                                         input longint cs, input longint sn);
    longint d, q, phase, nx, np;
    d = clip32(x - shift);
    q = qdiv(p, mw);
    phase = clip32(qmul(d, sn) - qmul(q, cs - ONE_FX) + qmul(shift, wd));
    nx = clip32(qmul(d, cs) + qmul(q, sn) + shift);
    np = clip32(qmul(p, cs) - qmul(qmul(mw, d), sn));
    x = nx;
    p = np;
    return phase;
  endfunction

  function automatic out_item_t advance_mode(in_item_t it);
    out_item_t res;
    longint pos [2];
    longint w, c, x, p, mw, mw2, k, wd, cs, sn, shift, ph1, ph2, pre1, pre2, t1, t2;
    clip_flag = 1'b0;
    pos[0] = pos_left;
    pos[1] = pos_right;
    w = longint'(it.frequency);
    c = longint'(it.coupling);
    x = longint'(it.position_in);
    p = longint'(it.momentum_in);
    mw = qmul(mass_q, w);
    mw2 = qmul(mw, w);
    k = qdiv(c, mw2);
    wd = qmul(w, half_q);
    rotate(w, half_q, cs, sn);
    shift = qmul((pos[it.fwd_first] + pos[it.bwd_first]) >>> 1, k);
    ph1 = evolve_half(x, p, shift, mw, wd, cs, sn);
    shift = qmul((pos[it.fwd_second] + pos[it.bwd_second]) >>> 1, k);
    ph2 = evolve_half(x, p, shift, mw, wd, cs, sn);
    pre1 = qdiv(qmul(c, clip32(pos[it.fwd_first] - pos[it.bwd_first])), w);
    pre2 = qdiv(qmul(c, clip32(pos[it.fwd_second] - pos[it.bwd_second])), w);
    t1 = qmul(pre1, clip32(ph1 - longint'(it.ref_phase_first)));
    t2 = qmul(pre2, clip32(ph2 - longint'(it.ref_phase_second)));
    bath_action = clip32(bath_action + clip32(t1 + t2));
    res.total_action = '0;
    if (it.last_mode) begin
      res.total_action = fx_t'(bath_action);
      bath_action = 0;
    end
    res.position_out = fx_t'(x);
    res.momentum_out = fx_t'(p);
    res.action_final = it.last_mode;
    res.saturated    = clip_flag;
    return res;
  endfunction

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (mode_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_if.data);
      end else begin
        exp_res = mode_results_q.pop_front();
        if (out_if.data !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp pos %h mom %h act %h fin %b sat %b, ",
                      "got pos %h mom %h act %h fin %b sat %b"},
                     exp_res.position_out, exp_res.momentum_out, exp_res.total_action,
                     exp_res.action_final, exp_res.saturated,
                     out_if.data.position_out, out_if.data.momentum_out,
                     out_if.data.total_action, out_if.data.action_final,
                     out_if.data.saturated);
        end
      end
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
    out_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  task automatic send_mode(in_item_t it);
    while ($urandom_range(99) < send_gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    mode_results_q = {mode_results_q, advance_mode(it)};
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (mode_results_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_LEFT:  pos_left  = longint'(signed'(val));
      CFG_RIGHT: pos_right = longint'(signed'(val));
      CFG_MASS:  mass_q    = longint'(val[30:0]);
      default:   half_q    = longint'(val[30:0]);
    endcase
  endtask

  task automatic set_bath(logic [31:0] l, logic [31:0] r, logic [31:0] m, logic [31:0] h);
    drain();
    write_reg(CFG_LEFT, l);
    write_reg(CFG_RIGHT, r);
    write_reg(CFG_MASS, m);
    write_reg(CFG_HALF, h);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic in_item_t random_mode(bit wild);
    in_item_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    if (!wild) begin
      it.frequency        = 31'($urandom_range(32'h0004_0000, 32'h0000_2000));
      it.coupling         = fx_t'($signed($urandom_range(32'h0002_0000)) - 32'sh0001_0000);
      it.position_in      = fx_t'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
      it.momentum_in      = fx_t'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
      it.ref_phase_first  = fx_t'($signed($urandom_range(32'h0000_4000)) - 32'sh0000_2000);
      it.ref_phase_second = fx_t'($signed($urandom_range(32'h0000_4000)) - 32'sh0000_2000);
      it.last_mode        = ($urandom_range(7) == 0);
    end
    if (it.frequency == 0) it.frequency = 31'd1;
    return it;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send_mode(random_mode($urandom_range(99) < 20));
  endtask

  task automatic test_directed();
    in_item_t it;
    logic [31:0] ext [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000};
    for (int s = 0; s < 16; s++) begin
      it = random_mode(1'b0);
      {it.fwd_first, it.bwd_first, it.fwd_second, it.bwd_second} = 4'(s);
      it.last_mode = s[0];
      send_mode(it);
    end
    for (int e = 0; e < 4; e++) begin
      it = random_mode(1'b0);
      it.coupling = ext[e];
      it.position_in = ext[(e + 1) % 4];
      it.momentum_in = ext[(e + 2) % 4];
      it.ref_phase_first = ext[(e + 3) % 4];
      it.ref_phase_second = ext[e];
      it.frequency = (e[0]) ? 31'h7fff_ffff : 31'd1;
      it.last_mode = 1'b1;
      send_mode(it);
    end
  endtask

  task automatic test_bath_settings();
    set_bath(32'h8000_0000, 32'h7fff_ffff, 32'd1, 32'd1);
    run_random(20);
    set_bath(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    run_random(20);
    set_bath(32'hfffe_0000, 32'h0000_8000, 32'h0002_0000, 32'd800);
    run_random(40);
    set_bath(32'hffff_0000, 32'h0001_0000, 32'h0001_0000, 32'd3277);
  endtask

  task automatic test_pause();
    run_random(10);
    drain();
    run_random(10);
  endtask

  task automatic test_stream(int gap, int stall, int n);
    send_gap_pct  = gap;
    rcv_stall_pct = stall;
    run_random(n);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_LEFT;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    send_gap_pct = 32;
    rcv_stall_pct = 62;
    pos_left = -65536;
    pos_right = 65536;
    mass_q = 65536;
    half_q = 3277;
    bath_action = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_bath_settings();
    test_pause();
    test_stream(32, 62, 400);
    set_bath($urandom_range(32'h0004_0000) - 32'h0002_0000, $urandom_range(32'h0004_0000),
             $urandom_range(32'h0004_0000, 1), $urandom_range(32'h2000, 1));
    test_stream(62, 32, 400);
    test_stream(0, 0, 400);
    drain();
    if (mismatches == 0 && mode_results_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hbm_pkg.sv
rtl/hbm_if.sv
rtl/hbm_div.sv
rtl/hbm_cordic.sv
rtl/hbm_front.sv
rtl/hbm_back.sv
rtl/harmonic_bath_mode_step.sv
sim/tb.sv
